### hw/rtl/dpoc_pkg.sv
// ============================================================================
// dpoc_pkg - shared types and constants for the dust pulse occupancy block
// Beat structs, sequencer states, register indexes and Q16/Q32 coefficients.
// ============================================================================
package dpoc_pkg;

    // Input beat: one measured low pulse
    typedef struct packed {
        logic [19:0] pulse_us;
        logic        window_end;
    } in_item_t;

    // Output beat: one concentration pair per closed window
    typedef struct packed {
        logic [20:0] raw_concentration;
        logic [20:0] filtered_concentration;
    } out_item_t;

    // Configuration register indexes
    localparam logic CFG_FILTER_ENABLE = 1'b0;
    localparam logic CFG_SAMPLE_TIME   = 1'b1;

    localparam logic [15:0] SAMPLE_TIME_RST = 16'd30000;

    // Datapath widths
    localparam int TOTAL_W = 32;
    localparam int DVD_W   = 48;   // ratio dividend: total << 16
    localparam int DVS_W   = 20;   // divisor: sample_time_ms * 10
    localparam int QUO_W   = 32;
    localparam int R_W     = 24;   // Q8.16 ratio
    localparam int R2_W    = 32;
    localparam int ACC_W   = 64;
    localparam int MB_W    = 26;   // widest serial multiplier operand
    localparam int CONC_W  = 21;

    localparam logic [5:0] DIV_LAST = 6'd47;

    // Polynomial coefficients in Q16, offset in Q32
    localparam logic [MB_W-1:0]  C3_Q16 = 26'd72090;
    localparam logic [MB_W-1:0]  C2_Q16 = 26'd249037;
    localparam logic [MB_W-1:0]  C1_Q16 = 26'd34078720;
    localparam logic [ACC_W-1:0] C0_Q32 = 64'd2662858752;

    // Conversion sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQ,
        ST_CUBE,
        ST_T3,
        ST_T1,
        ST_T2,
        ST_HIST,
        ST_OUT
    } dpoc_state_t;

endpackage

### hw/rtl/dust_pulse_occupancy_concentration_top.sv
// ============================================================================
// dust_pulse_occupancy_concentration_top - low-pulse occupancy to concentration
// Input beats carry one low-pulse duration; a beat with window_end closes the
// window and yields one output beat with raw and filtered concentration.
// A beat without window_end is taken while in_stall is low and the next may
// follow at once. A window_end beat starts a bit-serial conversion: a
// restoring divider (one quotient bit a cycle) and five shift-add multiplies
// (one multiplier bit a cycle, stopping when the operand runs out of ones)
// give the raw result. With the filter on and the history full, a second
// pass (mean divide plus conversion) gives the filtered result. in_stall is
// high from the closing beat until the result is in the output register.
// The result sits in an output register; pulses are taken while it waits,
// and a new result waits only until out_stall lets the old beat go.
// Reset clears the occupancy total, history count and head, sets
// filter_enable to 0 and sample_time_ms to 30000. History entries hold
// garbage until written. Config writes take effect from the next cycle.
// ============================================================================
module dust_pulse_occupancy_concentration_top #(
    parameter int WINDOW_LEN = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dpoc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output dpoc_pkg::out_item_t out_data,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);
    import dpoc_pkg::*;

    localparam int HEAD_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int HSUM_W = TOTAL_W + $clog2(WINDOW_LEN);

    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(WINDOW_LEN - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW_LEN);
    localparam logic [DVS_W-1:0]  WIN_DVS   = DVS_W'(WINDOW_LEN);

    // Control state
    dpoc_state_t        state_reg, state_next;
    logic               filter_enable_reg;
    logic [15:0]        sample_time_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0]   hist_count_reg, hist_count_next;
    logic [HEAD_W-1:0]  hist_head_reg, hist_head_next;
    logic [HSUM_W-1:0]  hist_sum_reg, hist_sum_next;
    logic               out_valid_reg, out_valid_next;
    logic [5:0]         div_cnt_reg, div_cnt_next;

    // Datapath
    logic [TOTAL_W-1:0] conv_total_reg, conv_total_next;
    logic               mean_reg, mean_next;      // divider runs the history mean
    logic               pass_filt_reg, pass_filt_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic [DVS_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic               quo_ovf_reg, quo_ovf_next;
    logic [R_W-1:0]     r_reg, r_next;
    logic [R2_W-1:0]    r2_reg, r2_next;
    logic [ACC_W-1:0]   mul_a_reg, mul_a_next;
    logic [MB_W-1:0]    mul_b_reg, mul_b_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [CONC_W-1:0]  raw_reg, raw_next;
    logic [CONC_W-1:0]  filt_reg, filt_next;
    out_item_t          out_data_reg, out_data_next;

    // History memory
    logic [TOTAL_W-1:0] hist_mem [WINDOW_LEN];
    logic [TOTAL_W-1:0] hist_rd_reg;
    logic               hist_we;

    // Per-cycle helpers
    logic [TOTAL_W:0]   add_sum;
    logic [DVS_W-1:0]   st10;
    logic [DVS_W:0]     trial;
    logic [DVS_W:0]     trial_diff;
    logic               q_bit;
    logic [QUO_W-1:0]   quo_step;
    logic               ovf_step;
    logic [R_W-1:0]     r_sat;
    logic [ACC_W-1:0]   acc_step;
    logic [CONC_W-1:0]  conc;
    logic [HSUM_W-1:0]  hist_sum_upd;

    // Divisor for the ratio: sample time times ten, zero read as one
    always_comb
    begin
        if (sample_time_reg == 16'd0)
        begin
            st10 = DVS_W'(10);
        end
        else
        begin
            st10 = (DVS_W'(sample_time_reg) << 3) + (DVS_W'(sample_time_reg) << 1);
        end
    end

    // Pulse sum, one restoring divide step, one multiply step, the conversion tail and the history sum update
    always_comb
    begin
        add_sum    = {1'b0, total_reg} + (TOTAL_W + 1)'(in_data.pulse_us);
        trial      = {rem_reg, dvd_reg[DVD_W-1]};
        trial_diff = trial - {1'b0, dvs_reg};
        q_bit      = !trial_diff[DVS_W];
        quo_step   = {quo_reg[QUO_W-2:0], q_bit};
        ovf_step   = quo_ovf_reg | quo_reg[QUO_W-1];
        r_sat      = (ovf_step || (quo_step[QUO_W-1:R_W] != '0)) ? '1 : quo_step[R_W-1:0];

        if (!mul_b_reg[0])
        begin
            acc_step = acc_reg;
        end
        else if (state_reg == ST_T2)
        begin
            acc_step = acc_reg - mul_a_reg;
        end
        else
        begin
            acc_step = acc_reg + mul_a_reg;
        end

        // Negative or zero clamps to zero, large values to full scale
        if (acc_reg[ACC_W-1])
        begin
            conc = '0;
        end
        else if (acc_reg[ACC_W-2:CONC_W+32] != '0)
        begin
            conc = '1;
        end
        else
        begin
            conc = acc_reg[CONC_W+31:32];
        end

        if (hist_count_reg < CNT_FULL)
        begin
            hist_sum_upd = hist_sum_reg + HSUM_W'(conv_total_reg);
        end
        else
        begin
            hist_sum_upd = hist_sum_reg - HSUM_W'(hist_rd_reg) + HSUM_W'(conv_total_reg);
        end
    end

    // Sequencer: next state and datapath loads
    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        hist_count_next = hist_count_reg;
        hist_head_next  = hist_head_reg;
        hist_sum_next   = hist_sum_reg;
        out_valid_next  = out_valid_reg & out_stall;
        div_cnt_next    = div_cnt_reg;
        conv_total_next = conv_total_reg;
        mean_next       = mean_reg;
        pass_filt_next  = pass_filt_reg;
        dvd_next        = dvd_reg;
        dvs_next        = dvs_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        quo_ovf_next    = quo_ovf_reg;
        r_next          = r_reg;
        r2_next         = r2_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        acc_next        = acc_reg;
        raw_next        = raw_reg;
        filt_next       = filt_reg;
        out_data_next   = out_data_reg;
        hist_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // Accumulate with saturation; a closing beat starts conversion
                    if (add_sum[TOTAL_W])
                    begin
                        total_next = '1;
                    end
                    else
                    begin
                        total_next = add_sum[TOTAL_W-1:0];
                    end
                    if (in_data.window_end)
                    begin
                        conv_total_next = total_next;
                        total_next      = '0;
                        mean_next       = 1'b0;
                        pass_filt_next  = 1'b0;
                        dvd_next        = {conv_total_next, 16'd0};
                        dvs_next        = st10;
                        rem_next        = '0;
                        quo_next        = '0;
                        quo_ovf_next    = 1'b0;
                        div_cnt_next    = '0;
                        state_next      = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                // Shift one quotient bit per cycle
                dvd_next     = dvd_reg << 1;
                rem_next     = q_bit ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
                quo_next     = quo_step;
                quo_ovf_next = ovf_step;
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    if (mean_reg)
                    begin
                        // Mean ready: divide it by sample time times ten for the ratio
                        mean_next    = 1'b0;
                        dvd_next     = {quo_step, 16'd0};
                        dvs_next     = st10;
                        rem_next     = '0;
                        quo_next     = '0;
                        quo_ovf_next = 1'b0;
                        div_cnt_next = '0;
                    end
                    else
                    begin
                        r_next     = r_sat;
                        mul_a_next = ACC_W'(r_sat);
                        mul_b_next = MB_W'(r_sat);
                        acc_next   = '0;
                        state_next = ST_SQ;
                    end
                end
            end

            ST_SQ, ST_CUBE, ST_T3, ST_T1, ST_T2:
            begin
                if (mul_b_reg != '0)
                begin
                    // Consume one multiplier bit
                    acc_next   = acc_step;
                    mul_a_next = mul_a_reg << 1;
                    mul_b_next = mul_b_reg >> 1;
                end
                else
                begin
                    case (state_reg)
                        ST_SQ:
                        begin
                            r2_next    = acc_reg[R2_W+15:16];
                            mul_a_next = ACC_W'(acc_reg[R2_W+15:16]);
                            mul_b_next = MB_W'(r_reg);
                            acc_next   = '0;
                            state_next = ST_CUBE;
                        end
                        ST_CUBE:
                        begin
                            mul_a_next = ACC_W'(acc_reg[ACC_W-9:16]);
                            mul_b_next = C3_Q16;
                            acc_next   = C0_Q32;
                            state_next = ST_T3;
                        end
                        ST_T3:
                        begin
                            mul_a_next = ACC_W'(r_reg);
                            mul_b_next = C1_Q16;
                            state_next = ST_T1;
                        end
                        ST_T1:
                        begin
                            mul_a_next = ACC_W'(r2_reg);
                            mul_b_next = C2_Q16;
                            state_next = ST_T2;
                        end
                        default:
                        begin
                            // Polynomial done
                            if (pass_filt_reg)
                            begin
                                filt_next  = conc;
                                state_next = ST_OUT;
                            end
                            else if (filter_enable_reg)
                            begin
                                raw_next   = conc;
                                state_next = ST_HIST;
                            end
                            else
                            begin
                                raw_next   = conc;
                                filt_next  = conc;
                                state_next = ST_OUT;
                            end
                        end
                    endcase
                end
            end

            ST_HIST:
            begin
                // Write the new total at the head, replacing the oldest entry once full, and update the running sum
                hist_we        = 1'b1;
                hist_sum_next  = hist_sum_upd;
                hist_head_next = (hist_head_reg == HEAD_LAST) ? '0 : hist_head_reg + 1'b1;
                if (hist_count_reg < CNT_FULL)
                begin
                    hist_count_next = hist_count_reg + 1'b1;
                    filt_next       = raw_reg;
                    state_next      = ST_OUT;
                end
                else
                begin
                    mean_next      = 1'b1;
                    pass_filt_next = 1'b1;
                    dvd_next       = DVD_W'(hist_sum_upd);
                    dvs_next       = WIN_DVS;
                    rem_next       = '0;
                    quo_next       = '0;
                    quo_ovf_next   = 1'b0;
                    div_cnt_next   = '0;
                    state_next     = ST_DIV;
                end
            end

            ST_OUT:
            begin
                // Load the output register once the previous beat has gone
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                       = 1'b1;
                    out_data_next.raw_concentration      = raw_reg;
                    out_data_next.filtered_concentration = filt_reg;
                    state_next                           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            filter_enable_reg <= 1'b0;
            sample_time_reg   <= SAMPLE_TIME_RST;
            total_reg         <= '0;
            hist_count_reg    <= '0;
            hist_head_reg     <= '0;
            hist_sum_reg      <= '0;
            out_valid_reg     <= 1'b0;
            div_cnt_reg       <= '0;
            mean_reg          <= 1'b0;
            pass_filt_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            hist_count_reg <= hist_count_next;
            hist_head_reg  <= hist_head_next;
            hist_sum_reg   <= hist_sum_next;
            out_valid_reg  <= out_valid_next;
            div_cnt_reg    <= div_cnt_next;
            mean_reg       <= mean_next;
            pass_filt_reg  <= pass_filt_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                    CFG_SAMPLE_TIME:   sample_time_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        conv_total_reg <= conv_total_next;
        dvd_reg        <= dvd_next;
        dvs_reg        <= dvs_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        quo_ovf_reg    <= quo_ovf_next;
        r_reg          <= r_next;
        r2_reg         <= r2_next;
        mul_a_reg      <= mul_a_next;
        mul_b_reg      <= mul_b_next;
        acc_reg        <= acc_next;
        raw_reg        <= raw_next;
        filt_reg       <= filt_next;
        out_data_reg   <= out_data_next;
    end

    // History memory: one write port, registered read at the head
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_head_reg] <= conv_total_reg;
        end
        hist_rd_reg <= hist_mem[hist_head_reg];
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // A new result only appears out of the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("output valid rose outside the output state");

    // History fill count never passes the window length
    assert property (@(posedge clk) disable iff (!rst_n)
        hist_count_reg <= CNT_FULL)
        else $error("history count overflow");

    // Divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < dvs_reg)
        else $error("divider remainder out of range");

    // A pending result is never overwritten while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_valid_reg && out_stall) |=> state_reg == ST_OUT)
        else $error("result left output state while slot busy");
`endif

endmodule

### tb/dust_pulse_occupancy_concentration_top_test.sv
`timescale 1ns / 100ps
// ============================================================================
// dust_pulse_occupancy_concentration_top_test - occupancy/concentration check
// Sends pulse beats grouped into sample windows through the block under
// random sender gaps and receiver stalls. A local copy of the occupancy
// total, the moving-average history and the Q16 cubic conversion predicts
// each window's raw and filtered concentration. Each output beat is compared
// field by field. Phases change filter_enable and sample_time_ms only while
// the block is drained.
// ============================================================================
module dust_pulse_occupancy_concentration_top_test;
    import dpoc_pkg::*;

    localparam int          HIST_DEPTH  = 8;
    localparam logic [63:0] COEF_CUBE   = 64'd72090;
    localparam logic [63:0] COEF_SQUARE = 64'd249037;
    localparam logic [63:0] COEF_LINEAR = 64'd34078720;
    localparam logic [63:0] COEF_OFFSET = 64'd40632;
    localparam logic [63:0] RATIO_MAX   = 64'hFF_FFFF;
    localparam logic [63:0] CONC_MAX    = 64'h1F_FFFF;
    localparam int          PHASE_SETTLE = 20;
    localparam int          END_SETTLE   = 400;
    localparam int          LONG_HOLD    = 1000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_FILTER_ENABLE;
    logic [15:0] cfg_data  = '0;

    // Predictor state
    logic        filter_cfg      = 1'b0;
    logic [15:0] sample_time_cfg = SAMPLE_TIME_RST;
    logic [31:0] occupancy       = '0;
    logic [31:0] window_totals [HIST_DEPTH];
    int          hist_count      = 0;
    int          hist_head       = 0;
    logic [63:0] hist_sum        = '0;

    in_item_t    pulse_q[$];
    out_item_t   pending_conc_q[$];
    int          errors     = 0;
    bit          gaps_on    = 1'b1;
    bit          force_hold = 1'b0;
    int          send_gap   = 0;
    int          recv_hold  = 0;

    dust_pulse_occupancy_concentration_top #(
        .WINDOW_LEN(HIST_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Ratio to sample time in Q8.16, then the cubic in Q32, truncated
    function automatic logic [20:0] concentration_of(input logic [31:0] total);
        logic [63:0] divisor;
        logic [63:0] ratio;
        logic [63:0] ratio_sq;
        logic [63:0] ratio_cu;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] conc;
        divisor  = (sample_time_cfg == 16'd0) ? 64'd10 : 64'(sample_time_cfg) * 64'd10;
        ratio    = ({32'd0, total} << 16) / divisor;
        if (ratio > RATIO_MAX)
            ratio = RATIO_MAX;
        ratio_sq = (ratio * ratio) >> 16;
        ratio_cu = (ratio_sq * ratio) >> 16;
        pos      = COEF_CUBE * ratio_cu + COEF_LINEAR * ratio + (COEF_OFFSET << 16);
        neg      = COEF_SQUARE * ratio_sq;
        if (pos <= neg)
            return '0;
        conc = (pos - neg) >> 32;
        return (conc > CONC_MAX) ? CONC_MAX[20:0] : conc[20:0];
    endfunction

    // Accumulate one pulse; on a window close, queue the expected beat
    function automatic void predict_pulse(input in_item_t beat);
        logic [32:0] sum;
        logic [31:0] total;
        out_item_t   res;
        sum       = {1'b0, occupancy} + 33'(beat.pulse_us);
        occupancy = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (!beat.window_end)
            return;
        total                      = occupancy;
        res.raw_concentration      = concentration_of(total);
        res.filtered_concentration = res.raw_concentration;
        if (filter_cfg)
        begin
            if (hist_count < HIST_DEPTH)
            begin
                window_totals[hist_head] = total;
                hist_sum                 = hist_sum + total;
                hist_count++;
            end
            else
            begin
                hist_sum                   = hist_sum - window_totals[hist_head] + total;
                window_totals[hist_head]   = total;
                res.filtered_concentration = concentration_of(32'(hist_sum / HIST_DEPTH));
            end
            hist_head = (hist_head + 1) % HIST_DEPTH;
        end
        occupancy = '0;
        pending_conc_q.push_back(res);
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 120);
    endfunction

    function automatic logic [19:0] pick_pulse();
        case ($urandom_range(0, 9))
            0:       return 20'd0;
            1:       return 20'hF_FFFF;
            2, 3:    return 20'($urandom_range(0, 255));
            4, 5:    return 20'($urandom_range(0, 65535));
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_sample_time();
        case ($urandom_range(0, 7))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 50));
            3, 4:    return 16'($urandom_range(51, 2000));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic push_pulse(input logic [19:0] pulse, input logic close);
        in_item_t beat;
        beat.pulse_us   = pulse;
        beat.window_end = close;
        pulse_q.push_back(beat);
    endtask

    // One window: random pulses, the last one closes it
    task automatic queue_window(input int pulses);
        for (int i = 0; i < pulses; i++)
            push_pulse(pick_pulse(), i == pulses - 1);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_FILTER_ENABLE)
            filter_cfg = val[0];
        else
            sample_time_cfg = val;
    endtask

    // Wait until every queued beat is taken and every result has come back
    task automatic wait_drained(input int settle);
        do
            @(posedge clk);
        while (pulse_q.size() != 0 || in_valid || pending_conc_q.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Driver: present queued beats, advance on acceptance, insert gaps
    always @(posedge clk)
    begin : drive_beats
        logic     next_valid;
        in_item_t next_data;
        next_valid = in_valid;
        next_data  = in_data;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_pulse(in_data);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pulse_q.size() != 0)
                begin
                    next_data  = pulse_q.pop_front();
                    next_valid = 1'b1;
                    send_gap   = gaps_on ? pick_gap() : 0;
                end
            end
        end
        in_valid <= next_valid;
        in_data  <= next_data;
    end

    // Monitor: check accepted beats, drive receiver stalls
    always @(posedge clk)
    begin : check_beats
        out_item_t want;
        logic      next_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_conc_q.size() == 0)
            begin
                $display("%0t: unexpected beat raw %0d filtered %0d", $time,
                         out_data.raw_concentration, out_data.filtered_concentration);
                errors++;
            end
            else
            begin
                want = pending_conc_q.pop_front();
                if (out_data.raw_concentration !== want.raw_concentration)
                begin
                    $display("%0t: raw_concentration expected %0d, got %0d", $time,
                             want.raw_concentration, out_data.raw_concentration);
                    errors++;
                end
                if (out_data.filtered_concentration !== want.filtered_concentration)
                begin
                    $display("%0t: filtered_concentration expected %0d, got %0d", $time,
                             want.filtered_concentration, out_data.filtered_concentration);
                    errors++;
                end
            end
        end
        if (force_hold)
        begin
            recv_hold  = LONG_HOLD;
            force_hold = 1'b0;
        end
        if (recv_hold > 0)
        begin
            recv_hold--;
            next_stall = 1'b1;
        end
        else
        begin
            next_stall = 1'b0;
            if (gaps_on)
                recv_hold = pick_gap();
        end
        out_stall <= next_stall;
    end

    // Stimulus
    initial
    begin : stimulus
        int filled;
        int pulses;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty window, extreme pulses, multi-pulse window
        push_pulse(20'd0, 1'b1);
        push_pulse(20'hF_FFFF, 1'b1);
        push_pulse(20'd1, 1'b0);
        push_pulse(20'hF_FFFF, 1'b0);
        push_pulse(20'h1_2345, 1'b1);
        push_pulse(20'd0, 1'b0);
        push_pulse(20'd0, 1'b1);
        wait_drained(PHASE_SETTLE);

        // Zero sample time behaves as one; ratio saturates
        write_reg(CFG_SAMPLE_TIME, 16'd0);
        push_pulse(20'hF_FFFF, 1'b1);
        push_pulse(20'd1, 1'b1);
        push_pulse(20'd0, 1'b1);
        wait_drained(PHASE_SETTLE);

        // Filter on at the longest sample time: warm-up and beyond
        write_reg(CFG_FILTER_ENABLE, 16'd1);
        write_reg(CFG_SAMPLE_TIME, 16'hFFFF);
        for (int i = 0; i < 11; i++)
            push_pulse((i % 3 == 0) ? 20'hF_FFFF : 20'($urandom), 1'b1);
        wait_drained(PHASE_SETTLE);

        // Long back-to-back window of maximum pulses, ratio saturated
        gaps_on = 1'b0;
        write_reg(CFG_SAMPLE_TIME, 16'd1);
        for (int i = 0; i < 400; i++)
            push_pulse(20'hF_FFFF, i == 399);
        push_pulse(20'd7, 1'b1);
        wait_drained(PHASE_SETTLE);

        // Random phases, each under its own settings
        for (int ph = 0; ph < 10; ph++)
        begin
            gaps_on = (ph != 2);
            write_reg(CFG_FILTER_ENABLE, 16'((ph % 4) != 3));
            write_reg(CFG_SAMPLE_TIME, pick_sample_time());
            filled = 0;
            while (filled < 130)
            begin
                if ($urandom_range(0, 9) == 0)
                    pulses = $urandom_range(13, 40);
                else
                    pulses = $urandom_range(1, 12);
                queue_window(pulses);
                filled += pulses;
            end
            // Hold the receiver off while beats keep coming
            if (ph == 4)
                force_hold = 1'b1;
            wait_drained(PHASE_SETTLE);
        end

        wait_drained(END_SETTLE);
        if (errors == 0 && pending_conc_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Timeout
    initial
    begin : watchdog
        #100_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/dpoc_pkg.sv
hw/rtl/dust_pulse_occupancy_concentration_top.sv
tb/dust_pulse_occupancy_concentration_top_test.sv
